### design/sfts_pkg.sv
package sfts_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int FRACTION_BITS = 16;
  localparam int MAX_SUBJECTS  = 64;

  localparam int POS_BITS   = $clog2(MAX_SUBJECTS);
  localparam int CNT_BITS   = POS_BITS + 1;
  localparam int VAL_BITS   = SAMPLE_BITS + 1;
  localparam int MAG_BITS   = SAMPLE_BITS;
  localparam int SQ_BITS    = 2 * MAG_BITS;
  localparam int SUM_BITS   = SAMPLE_BITS + POS_BITS + 1;
  localparam int SMAG_BITS  = SUM_BITS - 1;
  localparam int QSUM_BITS  = SQ_BITS + POS_BITS;
  localparam int S2_BITS    = 2 * SMAG_BITS;
  localparam int D_BITS     = QSUM_BITS + CNT_BITS;
  localparam int RHS_BITS   = S2_BITS + POS_BITS;
  localparam int DIV_STEPS  = RHS_BITS + 2 * FRACTION_BITS;
  localparam int Q_BITS     = 2 * SAMPLE_BITS - 1;
  localparam int ROOT_BITS  = SAMPLE_BITS - 1;
  localparam int SQRT_STEPS = ROOT_BITS;
  localparam int SQREM_BITS = ROOT_BITS + 3;
  localparam int STEP_BITS  = $clog2(DIV_STEPS);

  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 64;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SUBJECT_COUNT  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SIGN_FLIP_MASK = 1'd1;

  localparam logic [CNT_BITS-1:0] SUBJECT_COUNT_RESET = CNT_BITS'(MAX_SUBJECTS);

  typedef struct packed {
    logic load;
    logic acc;
    logic mul1;
    logic mul2;
    logic div_step;
    logic sqrt_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic valid;
    logic out_free;
  } sts_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_ACC  = 7'b0000010,
    ST_MUL1 = 7'b0000100,
    ST_MUL2 = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_SQRT = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

endpackage

### design/sfts_ctrl.sv
module sfts_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  sfts_pkg::sts_t  sts,
  output sfts_pkg::cmd_t  cmd
);
  import sfts_pkg::*;

  state_t               state_r, state_nxt;
  logic [STEP_BITS-1:0] cnt_r, cnt_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.last ? ST_MUL1 : ST_IDLE;
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!sts.valid) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.div_step = 1'b1;
          if (cnt_r == STEP_BITS'(DIV_STEPS - 1)) begin
            cnt_nxt   = '0;
            state_nxt = ST_SQRT;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt_r == STEP_BITS'(SQRT_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

### design/sfts_datapath.sv
module sfts_datapath (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_valid,
  input  logic [sfts_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [sfts_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  input  logic signed [sfts_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [sfts_pkg::SAMPLE_BITS-1:0] out_t_value,
  output logic                                    out_voxel_valid,
  output logic [sfts_pkg::CNT_BITS-1:0]           out_included_count,
  input  sfts_pkg::cmd_t                          cmd,
  output sfts_pkg::sts_t                          sts
);
  import sfts_pkg::*;

  logic [CNT_BITS-1:0]      subj_cnt_r;
  logic [MAX_SUBJECTS-1:0]  mask_r;

  logic signed [VAL_BITS-1:0] v_r;
  logic                       nz_r;
  logic                       last_r;

  logic signed [SUM_BITS-1:0] sum_r;
  logic [QSUM_BITS-1:0]       qsum_r;
  logic [CNT_BITS-1:0]        k_r;
  logic [POS_BITS-1:0]        pos_r;

  logic [S2_BITS-1:0]   s2_r;
  logic [D_BITS-1:0]    kq_r;
  logic [D_BITS-1:0]    d_r;
  logic [RHS_BITS-1:0]  dvd_r;
  logic                 valid_r;

  logic [D_BITS-1:0]     rem_r;
  logic [Q_BITS-1:0]     q_r;
  logic                  ovf_r;
  logic [SQREM_BITS-1:0] srem_r;
  logic [ROOT_BITS-1:0]  root_r;

  logic                       out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_t_r;
  logic                       out_vv_r;
  logic [CNT_BITS-1:0]        out_k_r;

  logic [CNT_BITS-1:0]        n_eff;
  logic                       last_now;
  logic signed [VAL_BITS-1:0] sext;
  logic [MAG_BITS-1:0]        vmag;
  logic [SMAG_BITS-1:0]       smag;
  logic [D_BITS-1:0]          d_now;
  logic                       valid_now;
  logic [D_BITS:0]            rem_sh;
  logic                       div_ge;
  logic [D_BITS:0]            rem_dif;
  logic [SQREM_BITS-1:0]      srem_sh;
  logic [SQREM_BITS-1:0]      trial;
  logic                       sq_ge;
  logic                       sat;
  logic [SAMPLE_BITS-1:0]     t_mag;
  logic [SAMPLE_BITS-1:0]     t_pos;
  logic [SAMPLE_BITS-1:0]     t_final;

  always_comb begin
    if (subj_cnt_r == '0) begin
      n_eff = CNT_BITS'(1);
    end else if (subj_cnt_r > CNT_BITS'(MAX_SUBJECTS)) begin
      n_eff = CNT_BITS'(MAX_SUBJECTS);
    end else begin
      n_eff = subj_cnt_r;
    end
  end

  assign last_now = (CNT_BITS'(pos_r) + CNT_BITS'(1)) >= n_eff;
  assign sext     = VAL_BITS'(in_sample);
  assign vmag     = v_r[VAL_BITS-1] ? MAG_BITS'(-v_r) : MAG_BITS'(v_r);
  assign smag     = sum_r[SUM_BITS-1] ? SMAG_BITS'(-sum_r) : SMAG_BITS'(sum_r);

  assign d_now     = kq_r - D_BITS'(s2_r);
  assign valid_now = ((CNT_BITS + 1)'(k_r) + (CNT_BITS + 1)'(2) >= (CNT_BITS + 1)'(n_eff))
                     && (k_r >= CNT_BITS'(2)) && (d_now != '0);

  assign rem_sh  = {rem_r, dvd_r[RHS_BITS-1]};
  assign div_ge  = rem_sh >= {1'b0, d_r};
  assign rem_dif = rem_sh - {1'b0, d_r};

  assign srem_sh = {srem_r[SQREM_BITS-3:0], q_r[Q_BITS-2 -: 2]};
  assign trial   = SQREM_BITS'({root_r, 2'b01});
  assign sq_ge   = srem_sh >= trial;

  assign sat     = ovf_r | q_r[Q_BITS-1];
  assign t_mag   = sat ? {1'b1, {ROOT_BITS{1'b0}}} : {1'b0, root_r};
  assign t_pos   = sat ? {1'b0, {ROOT_BITS{1'b1}}} : {1'b0, root_r};
  assign t_final = !valid_r ? '0 : (sum_r[SUM_BITS-1] ? (~t_mag + 1'b1) : t_pos);

  assign sts.last     = last_r;
  assign sts.valid    = valid_r;
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      subj_cnt_r <= SUBJECT_COUNT_RESET;
      mask_r     <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SUBJECT_COUNT:  subj_cnt_r <= cfg_data[CNT_BITS-1:0];
        CFG_SIGN_FLIP_MASK: mask_r     <= cfg_data[MAX_SUBJECTS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_r    <= mask_r[pos_r] ? -sext : sext;
      nz_r   <= (in_sample != '0);
      last_r <= last_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      qsum_r <= '0;
      k_r    <= '0;
      pos_r  <= '0;
    end else if (cmd.finish) begin
      sum_r  <= '0;
      qsum_r <= '0;
      k_r    <= '0;
      pos_r  <= '0;
    end else if (cmd.acc) begin
      if (nz_r) begin
        sum_r  <= sum_r + SUM_BITS'(v_r);
        qsum_r <= qsum_r + QSUM_BITS'(vmag * vmag);
        k_r    <= k_r + 1'b1;
      end
      if (!last_r) begin
        pos_r <= pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      s2_r <= S2_BITS'(smag * smag);
      kq_r <= D_BITS'(qsum_r * k_r);
    end
    if (cmd.mul2) begin
      d_r     <= d_now;
      valid_r <= valid_now;
      dvd_r   <= RHS_BITS'(s2_r * POS_BITS'(k_r - 1'b1));
      rem_r   <= '0;
      q_r     <= '0;
      ovf_r   <= 1'b0;
      srem_r  <= '0;
      root_r  <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= div_ge ? rem_dif[D_BITS-1:0] : rem_sh[D_BITS-1:0];
      dvd_r <= {dvd_r[RHS_BITS-2:0], 1'b0};
      ovf_r <= ovf_r | q_r[Q_BITS-1];
      q_r   <= {q_r[Q_BITS-2:0], div_ge};
    end
    if (cmd.sqrt_step) begin
      srem_r <= sq_ge ? (srem_sh - trial) : srem_sh;
      root_r <= {root_r[ROOT_BITS-2:0], sq_ge};
      q_r    <= {q_r[Q_BITS-1], q_r[Q_BITS-4:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_t_r  <= t_final;
      out_vv_r <= valid_r;
      out_k_r  <= k_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_t_value        = out_t_r;
  assign out_voxel_valid    = out_vv_r;
  assign out_included_count = out_k_r;

endmodule

### design/sign_flip_one_sample_t_statistic.sv
// channel | ports                                        | handshake
// input   | in_sample                                    | in_valid / in_stall
// result  | out_t_value out_voxel_valid out_included_count | out_valid / out_stall
// config  | cfg_index cfg_data                           | cfg_valid / cfg_ready
//
// Each sample is registered, then accumulated with one 24x24 square.
// The last sample of a voxel adds multiply states MUL1 and MUL2, a 98-step
// restoring divider, a 23-step bit-serial square root and a commit state;
// an invalid voxel skips divider and root (the divider state sees the skip).
// in_stall is high in every state but idle, so no new sample is taken until the last one is accumulated.
// Synchronous active-low reset clears accumulators and loads register defaults.
// A result waits in the output register; only a second result stalls the block.
module sign_flip_one_sample_t_statistic (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [sfts_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [sfts_pkg::SAMPLE_BITS-1:0] out_t_value,
  output logic                                    out_voxel_valid,
  output logic [sfts_pkg::CNT_BITS-1:0]           out_included_count,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [sfts_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [sfts_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
  import sfts_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  sfts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sfts_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_t_value        (out_t_value),
    .out_voxel_valid    (out_voxel_valid),
    .out_included_count (out_included_count),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule

### verif/tb_sign_flip_one_sample_t_statistic.sv
`timescale 1ns / 1ps

module tb_sign_flip_one_sample_t_statistic;
  import sfts_pkg::*;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] t_value;
    logic                   voxel_valid;
    logic [CNT_BITS-1:0]    included_count;
  } tstat_t;

  typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e                kind;
    logic [CFG_IDX_BITS-1:0]  idx;
    logic [CFG_DATA_BITS-1:0] val;
    logic [SAMPLE_BITS-1:0]   smp;
    bit                       typed;
    tstat_t                   want;
  } row_t;

  localparam logic [SAMPLE_BITS-1:0] T_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] T_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam int S_MAX = 8388607;
  localparam int S_MIN = -8388608;
  localparam int ONE = 65536;
  localparam int N_ROWS = 37;
  localparam int N_PHASES = 14;
  localparam int SETTLE_CYCLES = 10;
  localparam int DRAIN_CYCLES = 140;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  sample_t                  in_sample = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  sample_t                  out_t_value;
  logic                     out_voxel_valid;
  logic [CNT_BITS-1:0]      out_included_count;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  sign_flip_one_sample_t_statistic u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_t_value        (out_t_value),
    .out_voxel_valid    (out_voxel_valid),
    .out_included_count (out_included_count),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the block's registers and accumulators
  logic [CNT_BITS-1:0]      sh_count = CNT_BITS'(MAX_SUBJECTS);
  logic [CFG_DATA_BITS-1:0] sh_mask = '0;
  longint                   acc_sum = 0;
  longint unsigned          acc_sq = 0;
  int                       acc_k = 0;
  int                       acc_pos = 0;

  tstat_t pending_tstats[$];
  tstat_t got_r, want_r;
  row_t   dir_rows [N_ROWS];

  int errors = 0;
  int samples_sent = 0;
  int reg_writes = 0;
  int voxels_seen = 0;
  int voxels_valid = 0;
  int voxels_saturated = 0;
  int send_idle_pct = 9;
  int recv_idle_pct = 63;

  function automatic void fold_sample(input sample_t smp, output bit closes,
                                      output tstat_t r);
    longint          v;
    int              n;
    longint unsigned smag, lo, hi, mid;
    logic [127:0]    s2, d, rhs;
    bit              ok;
    v = smp;
    n = sh_count;
    if (n == 0) n = 1;
    if (n > MAX_SUBJECTS) n = MAX_SUBJECTS;
    r = '0;
    closes = 1'b0;
    if (v != 0) begin
      if (sh_mask[acc_pos]) v = -v;
      acc_sum += v;
      acc_sq += longint'(v * v);
      acc_k++;
    end
    if (acc_pos + 1 < n) begin
      acc_pos = (acc_pos + 1) % MAX_SUBJECTS;
      return;
    end
    closes = 1'b1;
    smag = (acc_sum < 0) ? -acc_sum : acc_sum;
    s2 = 128'(smag) * 128'(smag);
    d = 128'(acc_sq) * 128'(acc_k) - s2;
    ok = (acc_k + 2 >= n) && (acc_k >= 2) && (d != 0);
    lo = 0;
    if (ok) begin
      rhs = (s2 * 128'(acc_k - 1)) << (2 * FRACTION_BITS);
      hi = 64'd1 << (SAMPLE_BITS - 1);
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        if (d * 128'(mid * mid) <= rhs) lo = mid;
        else hi = mid - 1;
      end
      if (acc_sum >= 0) begin
        if (lo > 64'(T_MAX)) lo = 64'(T_MAX);
      end else begin
        lo = -lo;
      end
    end
    r.t_value = lo[SAMPLE_BITS-1:0];
    r.voxel_valid = ok;
    r.included_count = acc_k[CNT_BITS-1:0];
    acc_sum = 0;
    acc_sq = 0;
    acc_k = 0;
    acc_pos = 0;
  endfunction

  function automatic row_t row_smp(input int s);
    row_t r;
    r = '0;
    r.kind = ROW_SAMPLE;
    r.smp = s[SAMPLE_BITS-1:0];
    return r;
  endfunction

  function automatic row_t row_chk(input int s, input int t, input bit vv, input int k);
    row_t r;
    r = row_smp(s);
    r.typed = 1'b1;
    r.want.t_value = t[SAMPLE_BITS-1:0];
    r.want.voxel_valid = vv;
    r.want.included_count = k[CNT_BITS-1:0];
    return r;
  endfunction

  function automatic row_t row_cfg(input logic [CFG_IDX_BITS-1:0] idx,
                                   input logic [CFG_DATA_BITS-1:0] val);
    row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic sample_t pick_sample(input sample_t prev, input bit steady);
    int r;
    r = $urandom_range(99);
    if (steady && r < 70) return prev;
    if (r < 10) return '0;
    if (r < 16) begin
      case ($urandom_range(3))
        0: return T_MAX;
        1: return T_MIN;
        2: return sample_t'(1);
        default: return sample_t'(-1);
      endcase
    end
    if (r < 26) return prev;
    if (r < 40) return sample_t'(int'($urandom_range(511)) - 256);
    return sample_t'($urandom);
  endfunction

  task automatic wait_drained(input int extra);
    while (pending_tstats.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    in_valid <= 1'b0;
    wait_drained(SETTLE_CYCLES);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_SUBJECT_COUNT) sh_count = val[CNT_BITS-1:0];
    else if (idx == CFG_SIGN_FLIP_MASK) sh_mask = val;
    reg_writes++;
  endtask

  task automatic send_sample(input sample_t s, input bit typed, input tstat_t want);
    bit     closes;
    tstat_t pred;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
    fold_sample(s, closes, pred);
    if (closes) pending_tstats.push_back(typed ? want : pred);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_r.t_value = out_t_value;
      got_r.voxel_valid = out_voxel_valid;
      got_r.included_count = out_included_count;
      if (pending_tstats.size() == 0) begin
        if (errors < 10)
          $display("unexpected voxel result: t_value %0d voxel_valid %b included_count %0d",
                   $signed(got_r.t_value), got_r.voxel_valid, got_r.included_count);
        errors++;
      end else begin
        want_r = pending_tstats.pop_front();
        voxels_seen++;
        if (got_r.voxel_valid) voxels_valid++;
        if (got_r.voxel_valid && (got_r.t_value == T_MAX || got_r.t_value == T_MIN))
          voxels_saturated++;
        if (got_r != want_r) begin
          if (errors < 10)
            $display({"voxel %0d mismatch: t_value exp %0d got %0d, voxel_valid exp %b got %b,",
                      " included_count exp %0d got %0d"}, voxels_seen,
                     $signed(want_r.t_value), $signed(got_r.t_value),
                     want_r.voxel_valid, got_r.voxel_valid,
                     want_r.included_count, got_r.included_count);
          errors++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    #6000000;
    $display("timeout with %0d voxel results outstanding", pending_tstats.size());
    $display("[sign_flip_one_sample_t_statistic] ERROR");
    $finish;
  end

  initial begin
    int unsigned              phase_count [N_PHASES];
    int unsigned              cnt;
    logic [CFG_DATA_BITS-1:0] m;
    sample_t                  prev;
    bit                       steady;
    phase_count = '{127, 1, 2, 3, 4, 6, 8, 64, 3, 5, 2, 0, 12, 1};
    prev = sample_t'(ONE);
    dir_rows = '{
      // reset count of 64, then shortened mid-voxel; three equal samples
      row_smp(ONE), row_smp(ONE),
      row_cfg(CFG_SUBJECT_COUNT, 64'd2),
      row_chk(ONE, 0, 1'b0, 3),
      // single-subject voxels: zero, one sample, count 0 acting as 1
      row_cfg(CFG_SUBJECT_COUNT, 64'd1),
      row_chk(0, 0, 1'b0, 0),
      row_chk(S_MAX, 0, 1'b0, 1),
      row_cfg(CFG_SUBJECT_COUNT, 64'hFFFF_FFFF_FFFF_FF80),
      row_chk(S_MIN, 0, 1'b0, 1),
      row_cfg(CFG_SUBJECT_COUNT, 64'd2),
      row_smp(S_MAX), row_smp(S_MIN),
      // tiny variance saturates both ways
      row_cfg(CFG_SUBJECT_COUNT, 64'd3),
      row_smp(ONE), row_smp(ONE + 1), row_chk(ONE, S_MAX, 1'b1, 3),
      row_cfg(CFG_SIGN_FLIP_MASK, '1),
      row_smp(ONE), row_smp(ONE + 1), row_chk(ONE, S_MIN, 1'b1, 3),
      // zero mean
      row_cfg(CFG_SIGN_FLIP_MASK, '0),
      row_cfg(CFG_SUBJECT_COUNT, 64'd2),
      row_smp(100), row_chk(-100, 0, 1'b1, 2),
      // partial mask, and the n-2 inclusion threshold
      row_cfg(CFG_SUBJECT_COUNT, 64'd3),
      row_cfg(CFG_SIGN_FLIP_MASK, 64'h5),
      row_smp(5), row_smp(0), row_smp(7),
      row_cfg(CFG_SUBJECT_COUNT, 64'd5),
      row_smp(3), row_smp(0), row_smp(0), row_smp(0), row_chk(9, 0, 1'b0, 2),
      // count above the maximum acts as 64
      row_cfg(CFG_SUBJECT_COUNT, 64'd127),
      row_cfg(CFG_SIGN_FLIP_MASK, '0)
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_WRITE) write_reg(dir_rows[r].idx, dir_rows[r].val);
      else send_sample(dir_rows[r].smp, dir_rows[r].typed, dir_rows[r].want);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      steady = (p == 4 || p == 10);
      if (p == 5) begin
        send_idle_pct = 63;
        recv_idle_pct = 9;
      end
      if (p == 10) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p != 0) begin
        cnt = (p == N_PHASES - 1) ? $urandom_range(1, 20) : phase_count[p];
        write_reg(CFG_SUBJECT_COUNT, ({$urandom, $urandom} & ~64'h7F) | 64'(cnt));
        case (p % 3)
          0: m = {$urandom, $urandom};
          1: m = '1;
          default: m = '0;
        endcase
        if (steady) m = '0;
        write_reg(CFG_SIGN_FLIP_MASK, m);
      end
      for (int i = 0; i < ((p == 0) ? 130 : 45); i++) begin
        if ($urandom_range(99) < 2) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending_tstats.size() != 0) @(posedge clk);
        end
        prev = pick_sample(prev, steady);
        send_sample(prev, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    wait_drained(DRAIN_CYCLES);
    $display("sent %0d samples and %0d register writes over %0d setting phases",
             samples_sent, reg_writes, N_PHASES);
    $display("checked %0d voxel results: %0d valid, %0d saturated, %0d mismatches",
             voxels_seen, voxels_valid, voxels_saturated, errors);
    if (errors == 0) begin
      $display("[sign_flip_one_sample_t_statistic] OK");
    end else begin
      $display("[sign_flip_one_sample_t_statistic] ERROR");
    end
    $finish;
  end

endmodule

### sign_flip_one_sample_t_statistic.f
design/sfts_pkg.sv
design/sfts_ctrl.sv
design/sfts_datapath.sv
design/sign_flip_one_sample_t_statistic.sv
verif/tb_sign_flip_one_sample_t_statistic.sv
